// ===== rtl/dpie_pkg.sv =====
// dpie_pkg: encodings and shared types for the data-processing-immediate
// execute unit. No dependencies; imported by dp_immediate_execute_unit_top, dpie_checker and the testbench.
package dpie_pkg;

	// Instruction group, bits 25..23
	localparam logic [2:0] GRP_ARITH = 3'b010;
	localparam logic [2:0] GRP_WIDE  = 3'b101;

	// Wide-move opcodes, bits 30..29
	localparam logic [1:0] OPC_MOVN    = 2'b00;
	localparam logic [1:0] OPC_UNALLOC = 2'b01;
	localparam logic [1:0] OPC_MOVZ    = 2'b10;
	localparam logic [1:0] OPC_MOVK    = 2'b11;

	// Halfword lane mask for wide moves
	localparam logic [15:0] HALF_MASK = 16'hffff;

	// Register number that reads as zero and discards writes
	localparam logic [4:0] ZERO_REG = 5'd31;
	localparam int unsigned NUM_GPR = 31;

	// Program counter step per instruction
	localparam logic [63:0] PC_STEP = 64'd4;

	// Condition flags
	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} nzcv_t;

endpackage

// ===== rtl/dp_immediate_execute_unit_top.sv =====
// dp_immediate_execute_unit_top: execute stage for add/sub immediate and
// wide-move instructions, with a 31-entry register file, flags and PC.
// Depends on dpie_pkg.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------
//   instr    | instr_valid / instr_ready   | instruction[31:0]
//   result   | result_valid / result_ready | dest_index, write_enable,
//            |                             | write_value, flag_n/z/c/v, next_pc
//
// One word per cycle sustained while result_ready stays high; a word is held in the
// input register and its result is registered in the result register. Decode,
// register read, the 64-bit add and the register/flag/PC update all happen in
// one stage between those two registers, so the next word sees the previous
// word's writes. Reset clears all 31 registers, flags and PC at once. A stalled
// result holds the stage; the input register still takes one word behind it.
module dp_immediate_execute_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_ready,
	input  logic [31:0] instruction,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [4:0]  dest_index,
	output logic        write_enable,
	output logic [63:0] write_value,
	output logic        flag_n,
	output logic        flag_z,
	output logic        flag_c,
	output logic        flag_v,
	output logic [63:0] next_pc
);
	import dpie_pkg::*;

	// Input register
	logic        valid_s1;
	logic [31:0] instr_s1;

	// Architectural state
	logic [63:0] gpr_q [0:NUM_GPR-1];
	nzcv_t       flags_q;
	logic [63:0] pc_q;

	// Result register
	logic        out_valid_q;
	logic [4:0]  dest_q;
	logic        we_q;
	logic [63:0] wv_q;

	logic advance;
	logic exec_en;

	assign advance     = !out_valid_q || result_ready;
	assign exec_en     = valid_s1 && advance;
	assign instr_ready = !valid_s1 || advance;

	// Field decode
	logic        sf;
	logic [1:0]  opc;
	logic [2:0]  grp;
	logic [4:0]  rd;
	logic [4:0]  rn;
	logic [1:0]  hw;
	logic [4:0]  src_idx;
	logic [63:0] src_val;

	assign sf  = instr_s1[31];
	assign opc = instr_s1[30:29];
	assign grp = instr_s1[25:23];
	assign rd  = instr_s1[4:0];
	assign rn  = instr_s1[9:5];
	assign hw  = instr_s1[22:21];

	// Single read port: Rn for arithmetic, Rd for movk
	assign src_idx = (grp == GRP_ARITH) ? rn : rd;
	assign src_val = (src_idx == ZERO_REG) ? 64'd0 : gpr_q[src_idx];

	// Add/sub immediate
	logic [63:0] a_op;
	logic [63:0] b_imm;
	logic [63:0] b_op;
	logic        is_sub;
	logic [64:0] sum;
	logic [63:0] ar_res;
	logic        c32;
	logic        a_top;
	logic        b_top;
	logic        r_top;
	nzcv_t       ar_flags;

	assign is_sub = opc[1];
	assign a_op   = sf ? src_val : {32'd0, src_val[31:0]};
	assign b_imm  = instr_s1[22] ? {40'd0, instr_s1[21:10], 12'd0}
	                             : {52'd0, instr_s1[21:10]};
	assign b_op   = is_sub ? ~b_imm : b_imm;
	assign sum    = {1'b0, a_op} + {1'b0, b_op} + {64'd0, is_sub};
	// carry out of bit 31 recovered from the sum bit above it
	assign c32    = sum[32] ^ a_op[32] ^ b_op[32];
	assign ar_res = sf ? sum[63:0] : {32'd0, sum[31:0]};
	assign a_top  = sf ? a_op[63] : a_op[31];
	assign b_top  = sf ? b_imm[63] : b_imm[31];
	assign r_top  = sf ? ar_res[63] : ar_res[31];

	always_comb begin
		ar_flags.n = r_top;
		ar_flags.z = (ar_res == 64'd0);
		ar_flags.c = sf ? sum[64] : c32;
		if (is_sub) begin
			ar_flags.v = (a_top ^ b_top) & (a_top ^ r_top);
		end else begin
			ar_flags.v = ~(a_top ^ b_top) & (a_top ^ r_top);
		end
	end

	// Wide move
	logic [63:0] mv_imm;
	logic [63:0] mv_keep;
	logic [63:0] mv_mask;
	logic [63:0] mv_res;
	logic        mv_ok;

	assign mv_imm  = {48'd0, instr_s1[20:5]} << {hw, 4'b0000};
	assign mv_keep = ~({48'd0, HALF_MASK} << {hw, 4'b0000});
	assign mv_mask = sf ? {64{1'b1}} : {32'd0, {32{1'b1}}};
	assign mv_ok   = (grp == GRP_WIDE) && (opc != OPC_UNALLOC) && (sf || !hw[1]);

	always_comb begin
		case (opc)
			OPC_MOVN: mv_res = ~mv_imm & mv_mask;
			OPC_MOVZ: mv_res = mv_imm;
			OPC_MOVK: mv_res = (mv_imm | (src_val & mv_keep)) & mv_mask;
			default:  mv_res = 64'd0;
		endcase
	end

	// Writeback select
	logic        handled;
	logic        wr_en;
	logic [63:0] wr_val;
	logic        set_flags;

	assign handled   = (grp == GRP_ARITH) || mv_ok;
	assign wr_en     = handled && (rd != ZERO_REG);
	assign wr_val    = !wr_en ? 64'd0 : ((grp == GRP_ARITH) ? ar_res : mv_res);
	assign set_flags = (grp == GRP_ARITH) && opc[0];

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr_ready) begin
			valid_s1 <= instr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr_ready && instr_valid) begin
			instr_s1 <= instruction;
		end
	end

	// Register file, flags and PC update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GPR; i++) begin
				gpr_q[i] <= 64'd0;
			end
		end else if (exec_en && wr_en) begin
			gpr_q[rd] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			pc_q    <= 64'd0;
		end else if (exec_en) begin
			pc_q <= pc_q + PC_STEP;
			if (set_flags) begin
				flags_q <= ar_flags;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			dest_q <= rd;
			we_q   <= wr_en;
			wv_q   <= wr_val;
		end
	end

	// Flags and PC only change when a new result loads, so they ride
	// straight from the state registers
	assign result_valid = out_valid_q;
	assign dest_index   = dest_q;
	assign write_enable = we_q;
	assign write_value  = wv_q;
	assign flag_n       = flags_q.n;
	assign flag_z       = flags_q.z;
	assign flag_c       = flags_q.c;
	assign flag_v       = flags_q.v;
	assign next_pc      = pc_q;

endmodule

// ===== rtl/dpie_checker.sv =====
// dpie_checker: port-level checks for dp_immediate_execute_unit_top, bound
// to the top level below. Depends on dpie_pkg.
module dpie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [4:0]  dest_index,
	input logic        write_enable,
	input logic [63:0] write_value,
	input logic [63:0] next_pc
);
	import dpie_pkg::*;

	// Stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(dest_index)
			&& $stable(write_value) && $stable(write_enable))
		else $error("result word changed while stalled");

	// Zero register never written
	a_zero_reg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (dest_index == ZERO_REG) |-> !write_enable)
		else $error("write to zero register");

	// Dropped write shows a zero value
	a_no_write_val: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !write_enable |-> (write_value == 64'd0))
		else $error("nonzero value without write");

	// PC steps by four exactly once per new result
	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready |=>
			(result_valid && (next_pc == $past(next_pc) + PC_STEP))
			|| (!result_valid && (next_pc == $past(next_pc))))
		else $error("program counter step mismatch");

endmodule

bind dp_immediate_execute_unit_top dpie_checker u_dpie_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.dest_index   (dest_index),
	.write_enable (write_enable),
	.write_value  (write_value),
	.next_pc      (next_pc)
);

// ===== tb/dp_immediate_execute_unit_top_test.sv =====
// Self-checking testbench for dp_immediate_execute_unit_top: add/sub immediate and wide moves.
// Keeps its own register file, flags and PC model and checks every result word in order.
// Depends on dpie_pkg and the dp_immediate_execute_unit_top RTL.
module dp_immediate_execute_unit_top_test;
	import dpie_pkg::*;

	// add/sub immediate opcodes, bits 30..29
	localparam logic [1:0] OP_ADD  = 2'b00;
	localparam logic [1:0] OP_ADDS = 2'b01;
	localparam logic [1:0] OP_SUB  = 2'b10;
	localparam logic [1:0] OP_SUBS = 2'b11;
	// bits 28..26 of a real data-processing-immediate word
	localparam logic [2:0] CLASS_DPI = 3'b100;
	localparam logic [4:0] XZR = ZERO_REG;

	typedef struct packed {
		logic [4:0]  dest;
		logic        wr_en;
		logic [63:0] wr_val;
		nzcv_t       flags;
		logic [63:0] pc;
	} retire_t;

	logic        clk;
	logic        arst_n;
	logic        instr_valid;
	logic        instr_ready;
	logic [31:0] instruction;
	logic        result_valid;
	logic        result_ready;
	logic [4:0]  dest_index;
	logic        write_enable;
	logic [63:0] write_value;
	logic        flag_n;
	logic        flag_z;
	logic        flag_c;
	logic        flag_v;
	logic [63:0] next_pc;

	// architectural state of the predictor
	logic [63:0] arch_gpr [NUM_GPR];
	nzcv_t       arch_flags;
	logic [63:0] arch_pc;

	retire_t predicted_retires[$];
	int      fail_count = 0;
	int      hold_cycles = 0;
	bit      source_idle_on = 1'b1;
	bit      sink_idle_on = 1'b1;

	dp_immediate_execute_unit_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.instr_valid(instr_valid),
		.instr_ready(instr_ready),
		.instruction(instruction),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.dest_index(dest_index),
		.write_enable(write_enable),
		.write_value(write_value),
		.flag_n(flag_n),
		.flag_z(flag_z),
		.flag_c(flag_c),
		.flag_v(flag_v),
		.next_pc(next_pc)
	);

	always #10 clk = ~clk;

	// register 31 reads as zero
	function automatic logic [63:0] gpr_read(input logic [4:0] idx);
		return (idx == ZERO_REG) ? 64'd0 : arch_gpr[idx];
	endfunction

	// execute one word on the model state and return the retire record
	function automatic retire_t execute_instruction(input logic [31:0] word);
		logic        is_64;
		logic        is_sub;
		logic        handled;
		logic [1:0]  opc;
		logic [1:0]  hw;
		logic [2:0]  grp;
		logic [4:0]  rd;
		logic [4:0]  rn;
		logic [63:0] mask;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] r;
		logic [63:0] ovf;
		logic [63:0] lane;
		int          top;
		int          sh;
		retire_t     res;

		is_64 = word[31];
		opc = word[30:29];
		grp = word[25:23];
		hw = word[22:21];
		rd = word[4:0];
		rn = word[9:5];
		mask = is_64 ? {64{1'b1}} : 64'h0000_0000_ffff_ffff;
		top = is_64 ? 63 : 31;
		handled = 1'b0;
		r = '0;

		if (grp == GRP_ARITH) begin
			a = gpr_read(rn) & mask;
			b = word[22] ? {40'd0, word[21:10], 12'd0} : {52'd0, word[21:10]};
			is_sub = opc[1];
			if (is_sub) begin
				r = (a - b) & mask;
				ovf = (a ^ b) & (a ^ r);
			end else begin
				r = (a + b) & mask;
				ovf = ~(a ^ b) & (a ^ r);
			end
			// adds/subs update NZCV; carry on sub means no borrow
			if (opc[0]) begin
				arch_flags.n = r[top];
				arch_flags.z = (r == 64'd0);
				arch_flags.c = is_sub ? (a >= b) : (r < a);
				arch_flags.v = ovf[top];
			end
			handled = 1'b1;
		end else if (grp == GRP_WIDE && opc != OPC_UNALLOC && (is_64 || !hw[1])) begin
			sh = hw * 16;
			lane = {48'd0, word[20:5]} << sh;
			if (opc == OPC_MOVN)
				r = ~lane & mask;
			else if (opc == OPC_MOVZ)
				r = lane;
			else
				r = (lane | (gpr_read(rd) & ~({48'd0, HALF_MASK} << sh))) & mask;
			handled = 1'b1;
		end

		res.dest = rd;
		res.wr_en = handled && (rd != ZERO_REG);
		res.wr_val = res.wr_en ? r : 64'd0;
		if (res.wr_en)
			arch_gpr[rd] = r;
		arch_pc = arch_pc + PC_STEP;
		res.flags = arch_flags;
		res.pc = arch_pc;
		return res;
	endfunction

	function automatic logic [31:0] enc_arith(input logic sf, input logic [1:0] op,
			input logic shift12, input logic [11:0] imm, input logic [4:0] rn,
			input logic [4:0] rd);
		return {sf, op, CLASS_DPI, GRP_ARITH, shift12, imm, rn, rd};
	endfunction

	function automatic logic [31:0] enc_wide(input logic sf, input logic [1:0] op,
			input logic [1:0] hw, input logic [15:0] imm, input logic [4:0] rd);
		return {sf, op, CLASS_DPI, GRP_WIDE, hw, imm, rd};
	endfunction

	// mostly well-formed words over a small register window, some raw noise
	function automatic logic [31:0] random_word();
		int          pick;
		logic [4:0]  rd;
		logic [4:0]  rn;
		logic [11:0] imm12;
		logic [15:0] imm16;
		logic [31:0] word;

		pick = $urandom_range(0, 9);
		rd = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7));
		rn = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7));
		case ($urandom_range(0, 3))
			0: imm12 = 12'h000;
			1: imm12 = 12'hfff;
			default: imm12 = 12'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: imm16 = 16'h0000;
			1: imm16 = 16'hffff;
			default: imm16 = 16'($urandom);
		endcase
		if (pick < 5)
			word = enc_arith(1'($urandom), 2'($urandom), 1'($urandom), imm12, rn, rd);
		else if (pick < 9)
			word = enc_wide(1'($urandom), 2'($urandom), 2'($urandom), imm16, rd);
		else
			word = $urandom;
		// bits 28..26 are not decoded; vary them on structured words too
		if (pick < 9)
			word[28:26] = 3'($urandom);
		return word;
	endfunction

	// offer one word, wait for the handshake, predict its result
	task automatic send_word(input logic [31:0] word);
		int gap;

		gap = source_idle_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			instr_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instruction <= word;
		instr_valid <= 1'b1;
		do @(posedge clk); while (!instr_ready);
		predicted_retires.push_back(execute_instruction(word));
	endtask

	// stop offering and wait until every predicted word has retired
	task automatic wait_results_done();
		int waited;

		instr_valid <= 1'b0;
		waited = 0;
		while (predicted_retires.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (predicted_retires.size() != 0) begin
			$display("missing results: %0d still pending", predicted_retires.size());
			fail_count += predicted_retires.size();
			predicted_retires.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// extremes, every operation, zero register, unallocated and foreign encodings
	task automatic test_directed();
		send_word(enc_wide(1'b1, OPC_MOVZ, 2'd3, 16'hffff, 5'd0));
		send_word(enc_wide(1'b1, OPC_MOVK, 2'd0, 16'h1234, 5'd0));
		send_word(enc_wide(1'b1, OPC_MOVK, 2'd1, 16'habcd, 5'd0));
		send_word(enc_wide(1'b1, OPC_MOVK, 2'd2, 16'h0000, 5'd0));
		send_word(enc_wide(1'b1, OPC_MOVN, 2'd3, 16'h8000, 5'd1));
		send_word(enc_arith(1'b1, OP_ADDS, 1'b0, 12'd1, 5'd1, 5'd2));
		send_word(enc_wide(1'b1, OPC_MOVN, 2'd0, 16'h0000, 5'd7));
		send_word(enc_arith(1'b1, OP_ADDS, 1'b0, 12'd1, 5'd7, 5'd8));
		send_word(enc_arith(1'b1, OP_SUBS, 1'b0, 12'd1, XZR, 5'd3));
		send_word(enc_arith(1'b1, OP_SUBS, 1'b1, 12'hfff, 5'd7, 5'd9));
		send_word(enc_arith(1'b1, OP_SUBS, 1'b0, 12'd1, 5'd2, XZR));
		send_word(enc_arith(1'b1, OP_ADD, 1'b0, 12'hfff, XZR, 5'd10));
		send_word(enc_arith(1'b1, OP_SUB, 1'b1, 12'hfff, 5'd10, 5'd11));
		send_word(enc_wide(1'b0, OPC_MOVN, 2'd0, 16'h0000, 5'd4));
		send_word(enc_arith(1'b0, OP_ADDS, 1'b0, 12'd1, 5'd4, 5'd5));
		send_word(enc_wide(1'b0, OPC_MOVZ, 2'd1, 16'h7fff, 5'd12));
		send_word(enc_wide(1'b0, OPC_MOVK, 2'd0, 16'hffff, 5'd12));
		send_word(enc_arith(1'b0, OP_ADDS, 1'b0, 12'd1, 5'd12, 5'd13));
		send_word(enc_arith(1'b0, OP_SUBS, 1'b0, 12'd0, XZR, 5'd14));
		send_word(enc_arith(1'b0, OP_ADD, 1'b0, 12'd1, 5'd7, 5'd15));
		// 32-bit wide move to the upper halfwords is unallocated
		send_word(enc_wide(1'b0, OPC_MOVZ, 2'd2, 16'hffff, 5'd16));
		send_word(enc_wide(1'b0, OPC_MOVN, 2'd3, 16'h1234, 5'd16));
		send_word(enc_wide(1'b1, OPC_UNALLOC, 2'd1, 16'h5555, 5'd17));
		send_word(enc_wide(1'b1, OPC_MOVZ, 2'd0, 16'd5, XZR));
		send_word(enc_wide(1'b1, OPC_MOVK, 2'd3, 16'hffff, XZR));
		send_word(32'h0000_0000);
		send_word(32'hffff_ffff);
		wait_results_done();
	endtask

	// random words with idling on both sides, and a stretch without any
	task automatic test_random_mix();
		for (int i = 0; i < 300; i++) begin
			source_idle_on = !(i >= 150 && i < 210);
			sink_idle_on = source_idle_on;
			send_word(random_word());
		end
		source_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		wait_results_done();
	endtask

	// receiver holds off while words keep coming, so the input stalls
	task automatic test_backpressure();
		source_idle_on = 1'b0;
		hold_cycles = 80;
		for (int i = 0; i < 30; i++)
			send_word(random_word());
		source_idle_on = 1'b1;
		wait_results_done();
	endtask

	// sender pauses until the unit is empty, then resumes
	task automatic test_pause_and_resume();
		for (int i = 0; i < 25; i++)
			send_word(random_word());
		wait_results_done();
		for (int i = 0; i < 25; i++)
			send_word(random_word());
		wait_results_done();
	endtask

	// back-to-back words with the receiver always ready
	task automatic test_streaming();
		source_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		for (int i = 0; i < 50; i++)
			send_word(random_word());
		source_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		wait_results_done();
	endtask

	// result sink: random stalls per word, long hold when requested
	initial begin : result_sink
		int stall;

		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				result_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = sink_idle_on ? $urandom_range(0, 14) : 0;
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid && hold_cycles == 0);
		end
	end

	// compare each retired word with the oldest prediction
	always @(posedge clk) begin : check_results
		retire_t got;
		retire_t want;

		if (arst_n && result_valid && result_ready) begin
			got.dest = dest_index;
			got.wr_en = write_enable;
			got.wr_val = write_value;
			got.flags = {flag_n, flag_z, flag_c, flag_v};
			got.pc = next_pc;
			if (predicted_retires.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: rd=%0d we=%b val=%h nzcv=%b pc=%h",
						got.dest, got.wr_en, got.wr_val, got.flags, got.pc);
			end else begin
				want = predicted_retires.pop_front();
				if (got.dest !== want.dest || got.wr_en !== want.wr_en
						|| got.wr_val !== want.wr_val || got.flags !== want.flags
						|| got.pc !== want.pc) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch exp rd=%0d we=%b val=%h nzcv=%b pc=%h",
							want.dest, want.wr_en, want.wr_val, want.flags, want.pc);
						$display("         got rd=%0d we=%b val=%h nzcv=%b pc=%h",
							got.dest, got.wr_en, got.wr_val, got.flags, got.pc);
					end
				end
			end
		end
	end

	// run limit
	initial begin
		#(20 * 300000);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		instr_valid = 1'b0;
		instruction = '0;
		for (int i = 0; i < NUM_GPR; i++)
			arch_gpr[i] = '0;
		arch_flags = '0;
		arch_pc = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix();
		test_backpressure();
		test_pause_and_resume();
		test_streaming();
		wait_results_done();
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
